// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the RTL. Clock and active-low reset are
// passed in so a macro works in any clock domain.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// cond must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// ----- hdl/lppd_pkg.sv -----
// ----------------------------------------------------------------------------
// lppd_pkg
// Types and constants of the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lppd_pkg;

	// header layout (byte offsets within the packet)
	localparam logic [31:0] OFS_HLEN    = 32'd4;
	localparam logic [31:0] OFS_VER     = 32'd6;
	localparam logic [31:0] OFS_OP      = 32'd8;
	localparam logic [31:0] OFS_SEQ     = 32'd12;
	localparam logic [31:0] OFS_HDR_END = 32'd15;   // last fixed header byte
	localparam logic [15:0] MIN_HDR_LEN = 16'd16;

	localparam logic [15:0] VER_SKIP = 16'd2;
	localparam logic [15:0] VER_COMP = 16'd3;
	localparam logic [15:0] VER_MAX  = 16'd3;

	// result queue; depth must be a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_PAD    = 3'd1,
		PH_BODY   = 3'd2,
		PH_SKIP   = 3'd3,
		PH_STOP   = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_NONE      = 3'd0,
		ST_SKIPPED   = 3'd1,
		ST_ZERO_LEN  = 3'd2,
		ST_BAD_VER   = 3'd3,
		ST_MALFORMED = 3'd4,
		ST_TRUNC     = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0]  body_byte;
		logic        body_valid;
		logic [31:0] op_code;
		logic        is_compressed;
		logic        body_first;
		logic        body_last;
		status_t     status;
		logic        buffer_end;
	} result_t;

endpackage

`default_nettype wire

// ----- hdl/length_prefixed_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer
// Splits a byte stream of length-prefixed packets into body bytes tagged
// with the packet operation, and reports skipped packets and stop causes.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   in       | in_valid / in_ready  | in_byte, buffer_last
//   out      | out_valid / out_ready| body_byte, body_valid, op_code,
//            |                      | is_compressed, body_first, body_last,
//            |                      | status, buffer_end
//
// One byte per clock while the queue has room; the parser classifies a byte
// in the cycle it is accepted and writes its result into the queue on that
// same edge. From the queue the result passes to the output register, which
// holds it until the output transaction completes. Bytes that make no result
// produce nothing on the output. Reset is asynchronous and needs no
// clearing pass. With out_ready low the four-entry queue and the output
// register absorb five results before in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module length_prefixed_packet_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// byte input
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	input  wire logic        buffer_last,
	// result output
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       body_byte,
	output logic             body_valid,
	output logic [31:0]      op_code,
	output logic             is_compressed,
	output logic             body_first,
	output logic             body_last,
	output logic [2:0]       status,
	output logic             buffer_end
);
	import lppd_pkg::*;

	// parser -> queue
	logic    front_valid;
	result_t front_res;
	logic    q_push_ready;

	// queue -> output stage
	logic    q_pop_valid;
	result_t q_pop_data;
	logic    q_pop_ready;

	result_t out_res;

	// Front: header parsing, length checks, per-byte classification.
	// It runs whenever the queue has room, so a stalled output only backs
	// up the input once the queue fills.
	lppd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_byte    (in_byte),
		.buffer_last(buffer_last),
		.q_ready    (q_push_ready),
		.in_ready   (in_ready),
		.res_valid  (front_valid),
		.res        (front_res)
	);

	// Decouples the parser from output backpressure.
	lppd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(front_valid),
		.push_data (front_res),
		.push_ready(q_push_ready),
		.pop_valid (q_pop_valid),
		.pop_data  (q_pop_data),
		.pop_ready (q_pop_ready)
	);

	// Back: registered output, refilled in the cycle a transaction completes.
	lppd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_pop_valid),
		.q_data   (q_pop_data),
		.q_ready  (q_pop_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_res)
	);

	assign body_byte     = out_res.body_byte;
	assign body_valid    = out_res.body_valid;
	assign op_code       = out_res.op_code;
	assign is_compressed = out_res.is_compressed;
	assign body_first    = out_res.body_first;
	assign body_last     = out_res.body_last;
	assign status        = out_res.status;
	assign buffer_end    = out_res.buffer_end;

	// body markers and the compressed flag only come with a body byte
	`ASSERT_IMPL(a_marks_need_body, clk, arst_n,
		out_valid && (body_first || body_last || is_compressed), body_valid,
		"body marker without body byte")

	// a body byte never carries a skip or stop status
	`ASSERT_IMPL(a_body_status, clk, arst_n, out_valid && body_valid,
		(status == ST_NONE) || (status == ST_TRUNC),
		"body byte with skip or stop status")

	// without a body byte the data fields read as zero
	`ASSERT_IMPL(a_idle_fields_zero, clk, arst_n, out_valid && !body_valid,
		(body_byte == 8'd0) && (op_code == 32'd0),
		"nonzero data on a result without body byte")

	// truncation is only reported at the end of a buffer
	`ASSERT_IMPL(a_trunc_at_end, clk, arst_n, out_valid && (status == ST_TRUNC),
		buffer_end, "truncation reported before buffer end")

	// a result with nothing to say is never queued
	`ASSERT_NEVER(a_no_empty_result, clk, arst_n,
		front_valid && !front_res.body_valid && (front_res.status == ST_NONE) &&
		!front_res.buffer_end, "empty result pushed to queue")

endmodule

`default_nettype wire

// ----- hdl/lppd_front.sv -----
// ----------------------------------------------------------------------------
// lppd_front
// Header parser and byte classifier. Takes one byte per cycle while the queue
// has room and builds the result for it, if the byte produces one.
// ----------------------------------------------------------------------------
`default_nettype none

module lppd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [7:0]       in_byte,
	input  wire logic             buffer_last,
	input  wire logic             q_ready,
	output logic                  in_ready,
	output logic                  res_valid,
	output lppd_pkg::result_t     res
);
	import lppd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [31:0] pos_q, pos_d;
	logic [31:0] pkt_len_q, pkt_len_d;
	logic [15:0] hdr_len_q, hdr_len_d;
	logic [15:0] ver_q, ver_d;
	logic [31:0] op_q, op_d;

	logic        accept;
	logic [31:0] pos_inc;
	logic        close;
	phase_t      adv_phase;
	logic [31:0] adv_pos;
	logic        chk_zero, chk_ver, chk_mal, hdr_done;

	logic        valid, first, blast, done, emit;
	status_t     st;

	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;

	// advance past the current byte
	assign pos_inc = pos_q + 32'd1;
	assign close   = (pos_inc == pkt_len_q);
	assign adv_pos = close ? 32'd0 : pos_inc;
	always_comb begin
		if (close) begin
			adv_phase = PH_HEADER;
		end else if (pos_inc < {16'd0, hdr_len_q}) begin
			adv_phase = PH_PAD;
		end else if (ver_q == VER_SKIP) begin
			adv_phase = PH_SKIP;
		end else begin
			adv_phase = PH_BODY;
		end
	end

	// header checks, valid on the last fixed header byte
	assign hdr_done = (pos_q >= OFS_HDR_END);
	assign chk_zero = (pkt_len_q == {16'd0, hdr_len_q}) || (pkt_len_q == 32'd0);
	assign chk_ver  = (ver_q > VER_MAX);
	assign chk_mal  = (hdr_len_q < MIN_HDR_LEN) || ({16'd0, hdr_len_q} > pkt_len_q);

	// next state
	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		pkt_len_d = pkt_len_q;
		hdr_len_d = hdr_len_q;
		ver_d     = ver_q;
		op_d      = op_q;
		case (phase_q)
			PH_HEADER: begin
				if (pos_q < OFS_HLEN) begin
					pkt_len_d = {pkt_len_q[23:0], in_byte};
				end else if (pos_q < OFS_VER) begin
					hdr_len_d = {hdr_len_q[7:0], in_byte};
				end else if (pos_q < OFS_OP) begin
					ver_d = {ver_q[7:0], in_byte};
				end else if (pos_q < OFS_SEQ) begin
					op_d = {op_q[23:0], in_byte};
				end
				if (!hdr_done) begin
					pos_d = pos_inc;
				end else if (chk_zero || chk_ver || chk_mal) begin
					phase_d = PH_STOP;
				end else begin
					phase_d = adv_phase;
					pos_d   = adv_pos;
				end
			end
			PH_PAD, PH_SKIP, PH_BODY: begin
				phase_d = adv_phase;
				pos_d   = adv_pos;
			end
			default: begin
				phase_d = PH_STOP;
			end
		endcase
		if (buffer_last) begin
			phase_d = PH_HEADER;
			pos_d   = 32'd0;
		end
	end

	// result for the current byte
	always_comb begin
		valid = 1'b0;
		first = 1'b0;
		blast = 1'b0;
		done  = 1'b0;
		st    = ST_NONE;
		case (phase_q)
			PH_HEADER: begin
				if (hdr_done) begin
					if (chk_zero) begin
						st = ST_ZERO_LEN;
					end else if (chk_ver) begin
						st = ST_BAD_VER;
					end else if (chk_mal) begin
						st = ST_MALFORMED;
					end else begin
						done = close;
						if (ver_q == VER_SKIP) begin
							st = ST_SKIPPED;
						end
					end
				end
			end
			PH_PAD, PH_SKIP: begin
				done = close;
			end
			PH_BODY: begin
				valid = 1'b1;
				first = (pos_q == {16'd0, hdr_len_q});
				done  = close;
				blast = close;
			end
			default: begin
				done = 1'b0;
			end
		endcase
		if (buffer_last && (phase_q != PH_STOP) && !done &&
			!(st inside {ST_ZERO_LEN, ST_BAD_VER, ST_MALFORMED})) begin
			st = ST_TRUNC;
		end
		emit = valid || (st != ST_NONE) || buffer_last;

		res_valid         = accept && emit;
		res.body_byte     = valid ? in_byte : 8'd0;
		res.body_valid    = valid;
		res.op_code       = valid ? op_q : 32'd0;
		res.is_compressed = valid && (ver_q == VER_COMP);
		res.body_first    = first;
		res.body_last     = blast;
		res.status        = st;
		res.buffer_end    = buffer_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			pos_q     <= 32'd0;
			pkt_len_q <= 32'd0;
			hdr_len_q <= 16'd0;
			ver_q     <= 16'd0;
			op_q      <= 32'd0;
		end else if (accept) begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			pkt_len_q <= pkt_len_d;
			hdr_len_q <= hdr_len_d;
			ver_q     <= ver_d;
			op_q      <= op_d;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/lppd_queue.sv -----
// ----------------------------------------------------------------------------
// lppd_queue
// Short FIFO of results between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lppd_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	input  wire lppd_pkg::result_t push_data,
	output logic                  push_ready,
	output logic                  pop_valid,
	output lppd_pkg::result_t     pop_data,
	input  wire logic             pop_ready
);
	import lppd_pkg::*;

	result_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  push, pop;

	assign push_ready = (count_q < (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/lppd_back.sv -----
// ----------------------------------------------------------------------------
// lppd_back
// Output stage: holds one result on the output ports until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lppd_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire lppd_pkg::result_t q_data,
	output logic                  q_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output lppd_pkg::result_t     out_data
);
	import lppd_pkg::*;

	logic    out_valid_q;
	result_t out_data_q;
	logic    load;

	assign q_ready   = !out_valid_q || out_ready;
	assign load      = q_valid && q_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_ready) begin
			out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= q_data;
		end
	end

endmodule

`default_nettype wire

// ----- dv/tb_length_prefixed_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// tb_length_prefixed_packet_deframer
// Self-checking bench for the packet deframer. A directed table of packets
// (good ones of each version, every stop cause, truncation in each phase)
// is followed by random buffers, mostly well-formed packet trains with random
// content plus broken headers and noise. A behavioral deframer in the bench
// predicts every result; both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_length_prefixed_packet_deframer;
	timeunit 1ns;
	timeprecision 1ps;

	import lppd_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_BYTES = 600;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [7:0] NO_TYPED = 8'hFF;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        buffer_last;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  body_byte;
	logic        body_valid;
	logic [31:0] op_code;
	logic        is_compressed;
	logic        body_first;
	logic        body_last;
	logic [2:0]  status;
	logic        buffer_end;

	length_prefixed_packet_deframer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.buffer_last   (buffer_last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.body_byte     (body_byte),
		.body_valid    (body_valid),
		.op_code       (op_code),
		.is_compressed (is_compressed),
		.body_first    (body_first),
		.body_last     (body_last),
		.status        (status),
		.buffer_end    (buffer_end)
	);

	// ------------------------------------------------------------------
	// Deframer state as seen by the bench
	// ------------------------------------------------------------------
	phase_t      ph;
	logic [31:0] pos;       // offset inside the current packet
	logic [31:0] pkt_len;
	logic [15:0] hdr_len;
	logic [15:0] pkt_ver;
	logic [31:0] pkt_op;

	result_t expected_results[$];

	int fail_count;
	int cycles;
	int sent_bytes;         // bytes sent in the random part
	int in_wait_max;
	int out_wait_max;

	// Step past the byte just consumed; 1 when that byte closed the packet.
	function automatic bit step_pos();
		pos = pos + 1;
		if (pos == pkt_len) begin
			ph = PH_HEADER;
			pos = '0;
			return 1'b1;
		end
		if (pos < {16'd0, hdr_len})
			ph = PH_PAD;
		else
			ph = (pkt_ver == VER_SKIP) ? PH_SKIP : PH_BODY;
		return 1'b0;
	endfunction

	// Predict the outcome of one byte; has_result is 0 for silent bytes.
	function automatic void deframe_byte(input logic [7:0] b, input bit last,
			output bit has_result, output result_t r);
		phase_t      entry;
		logic [31:0] p;
		status_t     st;
		bit          valid;
		bit          first;
		bit          blast;
		bit          done;
		bit          stopped_now;

		entry = ph;
		p = pos;
		st = ST_NONE;
		valid = 1'b0;
		first = 1'b0;
		blast = 1'b0;
		done = 1'b0;

		case (entry)
			PH_HEADER: begin
				// big-endian fields shift in one byte at a time
				if (p < OFS_HLEN)
					pkt_len = {pkt_len[23:0], b};
				else if (p < OFS_VER)
					hdr_len = {hdr_len[7:0], b};
				else if (p < OFS_OP)
					pkt_ver = {pkt_ver[7:0], b};
				else if (p < OFS_SEQ)
					pkt_op = {pkt_op[23:0], b};

				if (p < OFS_HDR_END) begin
					pos = p + 1;
				end else if (pkt_len == {16'd0, hdr_len} || pkt_len == '0) begin
					st = ST_ZERO_LEN;
					ph = PH_STOP;
				end else if (pkt_ver > VER_MAX) begin
					st = ST_BAD_VER;
					ph = PH_STOP;
				end else if (hdr_len < MIN_HDR_LEN || {16'd0, hdr_len} > pkt_len) begin
					st = ST_MALFORMED;
					ph = PH_STOP;
				end else begin
					done = step_pos();
					if (pkt_ver == VER_SKIP)
						st = ST_SKIPPED;
				end
			end
			PH_PAD, PH_SKIP: begin
				done = step_pos();
			end
			PH_BODY: begin
				valid = 1'b1;
				first = (p == {16'd0, hdr_len});
				done = step_pos();
				blast = done;
			end
			default: begin
				ph = PH_STOP;
			end
		endcase

		// end of buffer: anything short of a finished packet or a fresh
		// stop is a truncation; the parser always restarts on a header
		if (last) begin
			stopped_now = (st == ST_ZERO_LEN || st == ST_BAD_VER || st == ST_MALFORMED);
			if (entry != PH_STOP && !done && !stopped_now)
				st = ST_TRUNC;
			ph = PH_HEADER;
			pos = '0;
		end

		has_result = valid || st != ST_NONE || last;
		r.body_byte = valid ? b : 8'd0;
		r.body_valid = valid;
		r.op_code = valid ? pkt_op : 32'd0;
		r.is_compressed = valid && pkt_ver == VER_COMP;
		r.body_first = first;
		r.body_last = blast;
		r.status = st;
		r.buffer_end = last;
	endfunction

	function automatic int pick_wait_max();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 3;
			default: return 17;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Clock, reset, watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Input side. Every call starts at a falling edge; the byte is held
	// until its transaction completes, then we return on the next
	// falling edge with valid still high, so back-to-back bytes never
	// see valid dropped and raised in one step.
	// ------------------------------------------------------------------
	task automatic push_byte(input logic [7:0] b, input bit last, input bit typed,
			input result_t typed_res);
		int      gap;
		bit      has_result;
		result_t r;

		gap = $urandom_range(0, in_wait_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		buffer_last <= last;
		do @(posedge clk); while (!in_ready);

		sent_bytes++;
		deframe_byte(b, last, has_result, r);
		// typed-in rows override the prediction for that one byte
		if (typed)
			expected_results.insert(expected_results.size(), typed_res);
		else if (has_result)
			expected_results.insert(expected_results.size(), r);
		@(negedge clk);
	endtask

	// Header bytes come from the fields, the rest is random content.
	task automatic send_packet(input logic [31:0] plen, input logic [15:0] hlen,
			input logic [15:0] vers, input logic [31:0] op, input int nbytes,
			input bit last_at_end, input int typed_at, input result_t typed_res);
		logic [127:0] hdr;
		logic [7:0]   b;
		int           i;

		hdr = {plen, hlen, vers, op, 32'($urandom)};
		for (i = 0; i < nbytes; i++) begin
			b = (i < 16) ? hdr[127 - 8 * i -: 8] : 8'($urandom);
			push_byte(b, last_at_end && i == nbytes - 1, i == typed_at, typed_res);
		end
	endtask

	// One random buffer: mostly a train of good packets, sometimes a
	// broken header (which ends the buffer after up to six dropped bytes),
	// an endless length, a cut-short tail, or plain noise.
	task automatic send_random_buffer();
		int          npk;
		int          k;
		int          n;
		int          kind;
		int          body;
		logic [31:0] plen;
		logic [15:0] hlen;
		logic [15:0] vers;
		bit          broken;
		bit          closing;

		in_wait_max = pick_wait_max();
		out_wait_max = pick_wait_max();

		if ($urandom_range(0, 19) == 0) begin
			n = $urandom_range(1, 40);
			for (k = 0; k < n; k++)
				push_byte(8'($urandom), k == n - 1, 1'b0, '0);
			return;
		end

		npk = $urandom_range(1, 4);
		for (k = 0; k < npk; k++) begin
			kind = $urandom_range(0, 99);
			hlen = 16'd16;
			if ($urandom_range(0, 3) == 0)
				hlen = 16'(16 + $urandom_range(1, 8));
			vers = 16'($urandom_range(0, 3));
			if ($urandom_range(0, 9) == 0)
				body = $urandom_range(25, 60);
			else
				body = $urandom_range(1, 24);
			plen = 32'(hlen) + 32'(body);
			n = int'(plen);
			broken = 1'b1;

			if (kind < 5) begin
				plen = $urandom_range(0, 1) ? 32'd0 : 32'(hlen);
			end else if (kind < 10) begin
				vers = 16'($urandom_range(4, 16'hFFFF));
			end else if (kind < 15) begin
				if ($urandom_range(0, 1))
					hlen = 16'($urandom_range(0, 15));
				else
					hlen = 16'($urandom_range(plen + 1, 16'hFFFF));
			end else if (kind < 18) begin
				// length far beyond anything sent: the buffer ends before the packet does
				plen = $urandom | 32'h0001_0000;
			end else begin
				broken = 1'b0;
			end

			if (broken)
				n = 16 + $urandom_range(0, 6);
			closing = broken || k == npk - 1;
			if (closing && n > 1 && $urandom_range(0, 4) == 0)
				n = $urandom_range(1, n - 1);
			send_packet(plen, hlen, vers, 32'($urandom), n, closing, NO_TYPED, '0);
			if (closing)
				break;
		end
	endtask

	// ------------------------------------------------------------------
	// Directed packets. Rows without a typed byte rely on the predictor;
	// typed rows give the expected stop or truncation result for one byte.
	// ------------------------------------------------------------------
	typedef struct packed {
		logic [31:0] plen;
		logic [15:0] hlen;
		logic [15:0] vers;
		logic [31:0] op;
		logic [7:0]  nbytes;
		logic        last;       // buffer_last on the final byte sent
		logic [7:0]  typed_at;   // byte whose result is typed in, or NO_TYPED
		status_t     typed_st;
		logic        typed_end;
	} packet_row_t;

	localparam int NUM_ROWS = 18;

	packet_row_t packet_rows [NUM_ROWS] = '{
		// plain body, first transaction after reset
		'{32'd20, 16'd16, 16'd0, 32'h0000_0000, 8'd20, 1'b0, NO_TYPED, ST_NONE, 1'b0},
		// two padding bytes, version 1, all-ones operation
		'{32'd21, 16'd18, 16'd1, 32'hFFFF_FFFF, 8'd21, 1'b0, NO_TYPED, ST_NONE, 1'b0},
		// compressed body
		'{32'd19, 16'd16, 16'd3, 32'h8000_0001, 8'd19, 1'b0, NO_TYPED, ST_NONE, 1'b0},
		// skipped body; buffer closes exactly on the packet end
		'{32'd22, 16'd16, 16'd2, 32'h0000_0007, 8'd22, 1'b1, 8'd15, ST_SKIPPED, 1'b0},
		// one-byte body: first and last on the same byte
		'{32'd17, 16'd16, 16'd0, 32'h1234_5678, 8'd17, 1'b1, NO_TYPED, ST_NONE, 1'b0},
		// packet length equals header length, then one dropped byte
		'{32'd16, 16'd16, 16'd0, 32'h0000_0001, 8'd17, 1'b1, 8'd15, ST_ZERO_LEN, 1'b0},
		// zero packet length, stop on the buffer's last byte
		'{32'd0, 16'd20, 16'd1, 32'h0000_0002, 8'd16, 1'b1, 8'd15, ST_ZERO_LEN, 1'b1},
		// highest version value
		'{32'd40, 16'd16, 16'hFFFF, 32'h0000_0003, 8'd20, 1'b1, 8'd15, ST_BAD_VER, 1'b0},
		// lowest unknown version, stop on the buffer's last byte
		'{32'd40, 16'd16, 16'd4, 32'h0000_0004, 8'd16, 1'b1, 8'd15, ST_BAD_VER, 1'b1},
		// header length one short of the fixed header
		'{32'd30, 16'd15, 16'd0, 32'h0000_0005, 8'd18, 1'b1, 8'd15, ST_MALFORMED, 1'b0},
		// header length at its maximum, beyond the packet
		'{32'd30, 16'hFFFF, 16'd1, 32'h0000_0006, 8'd18, 1'b1, 8'd15, ST_MALFORMED, 1'b0},
		// packet shorter than its header
		'{32'd1, 16'd16, 16'd0, 32'h0000_0007, 8'd16, 1'b1, 8'd15, ST_MALFORMED, 1'b1},
		// maximum packet length: body bytes until the buffer runs out
		'{32'hFFFF_FFFF, 16'd16, 16'd0, 32'hA5A5_5A5A, 8'd24, 1'b1, NO_TYPED, ST_NONE, 1'b0},
		// buffer ends inside the header
		'{32'd40, 16'd16, 16'd0, 32'h0000_0008, 8'd10, 1'b1, 8'd9, ST_TRUNC, 1'b1},
		// buffer ends inside the padding
		'{32'd40, 16'd30, 16'd1, 32'h0000_0009, 8'd20, 1'b1, 8'd19, ST_TRUNC, 1'b1},
		// buffer ends inside a skipped body
		'{32'd20, 16'd16, 16'd2, 32'h0000_000A, 8'd18, 1'b1, 8'd17, ST_TRUNC, 1'b1},
		// buffer ends on the last header byte of a skipped packet
		'{32'd30, 16'd16, 16'd2, 32'h0000_000B, 8'd16, 1'b1, 8'd15, ST_TRUNC, 1'b1},
		// single-byte buffer
		'{32'd24, 16'd16, 16'd0, 32'h0000_000C, 8'd1, 1'b1, 8'd0, ST_TRUNC, 1'b1}
	};

	// ------------------------------------------------------------------
	// Output side: a fresh stall drawn for every result
	// ------------------------------------------------------------------
	initial begin
		int stall;

		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = $urandom_range(0, out_wait_max);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic report_failure(input string what, input result_t want,
			input result_t got);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t %s: expected byte %h valid %b op %h comp %b first %b last %b",
				$realtime, what, want.body_byte, want.body_valid, want.op_code,
				want.is_compressed, want.body_first, want.body_last,
				" status %0d end %b | got byte %h valid %b op %h comp %b first %b",
				want.status, want.buffer_end, got.body_byte, got.body_valid,
				got.op_code, got.is_compressed, got.body_first,
				" last %b status %0d end %b", got.body_last, got.status, got.buffer_end);
	endtask

	// Sampled on the rising edge, before the block's registers move.
	always @(posedge clk) begin
		result_t got;
		result_t want;

		if (arst_n && out_valid && out_ready) begin
			got.body_byte = body_byte;
			got.body_valid = body_valid;
			got.op_code = op_code;
			got.is_compressed = is_compressed;
			got.body_first = body_first;
			got.body_last = body_last;
			got.status = status_t'(status);
			got.buffer_end = buffer_end;
			if (expected_results.size() == 0) begin
				report_failure("result with nothing expected", '0, got);
			end else begin
				want = expected_results.pop_front();
				if (got.body_byte !== want.body_byte || got.body_valid !== want.body_valid
						|| got.op_code !== want.op_code
						|| got.is_compressed !== want.is_compressed
						|| got.body_first !== want.body_first
						|| got.body_last !== want.body_last
						|| got.status !== want.status
						|| got.buffer_end !== want.buffer_end)
					report_failure("mismatch", want, got);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		result_t typed_res;
		int      i;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'd0;
		buffer_last = 1'b0;
		fail_count = 0;
		cycles = 0;
		sent_bytes = 0;
		in_wait_max = 0;
		out_wait_max = 0;

		ph = PH_HEADER;
		pos = '0;
		pkt_len = '0;
		hdr_len = '0;
		pkt_ver = '0;
		pkt_op = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table; the first rows run with no idling at all
		for (i = 0; i < NUM_ROWS; i++) begin
			if (i >= 4) begin
				in_wait_max = pick_wait_max();
				out_wait_max = pick_wait_max();
			end
			typed_res = '0;
			typed_res.status = packet_rows[i].typed_st;
			typed_res.buffer_end = packet_rows[i].typed_end;
			send_packet(packet_rows[i].plen, packet_rows[i].hlen, packet_rows[i].vers,
				packet_rows[i].op, int'(packet_rows[i].nbytes), packet_rows[i].last,
				(packet_rows[i].typed_at == NO_TYPED) ? -1 : int'(packet_rows[i].typed_at),
				typed_res);
		end

		// random buffers until enough bytes have been sent
		sent_bytes = 0;
		while (sent_bytes < RANDOM_BYTES)
			send_random_buffer();
		in_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		// stray results would show up within the pipeline latency
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
